// File: hdl/cleq_pkg.sv
package cleq_pkg;

  localparam int TAPS_DEF     = 32;
  localparam int TAP_BITS_DEF = 24;

  localparam int SMP_W   = 16;
  localparam int SMP_MAX = 32767;
  localparam int SMP_MIN = -32768;

  localparam int                STEP_W   = 16;
  localparam logic [STEP_W-1:0] STEP_RST = 16'd328;

  // 0.707 in Q2.13
  localparam int QPSK_LEVEL = 5792;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_start;
  } dl_req_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tap_req_t;

endpackage

// File: hdl/cleq_dline.sv
module cleq_dline
  import cleq_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dl_req_t            req_i,
  input  logic [2*SMP_W-1:0] wr_data_i,
  output logic [2*SMP_W-1:0] rd_data_o
);

  localparam int IW = $clog2(TAPS);

  logic [2*SMP_W-1:0] mem [TAPS];
  logic [2*SMP_W-1:0] rd_q;
  logic               rvld_q;
  logic [IW-1:0]      wptr_q, wptr_d;
  logic [IW-1:0]      rptr_q, rptr_d;
  logic [IW-1:0]      raddr;
  logic               full_q, full_d;

  // oldest sample sits at the write pointer
  assign raddr = req_i.rd_start ? wptr_q : rptr_q;

  always_comb begin
    wptr_d = wptr_q;
    full_d = full_q;
    rptr_d = rptr_q;
    if (req_i.wr_en) begin
      if (wptr_q == IW'(TAPS - 1)) begin
        wptr_d = '0;
        full_d = 1'b1;
      end else begin
        wptr_d = wptr_q + 1'b1;
      end
    end
    if (req_i.rd_en) begin
      rptr_d = (raddr == IW'(TAPS - 1)) ? '0 : raddr + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      full_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wptr_q] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_q   <= mem[raddr];
      rvld_q <= full_q || (raddr < wptr_q);
    end
  end

  // entries not yet written since reset read as zero
  assign rd_data_o = rvld_q ? rd_q : '0;

endmodule

// File: hdl/cleq_tapmem.sv
module cleq_tapmem
  import cleq_pkg::*;
#(
  parameter int TAPS     = TAPS_DEF,
  parameter int TAP_BITS = TAP_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tap_req_t                 req_i,
  input  logic [$clog2(TAPS)-1:0]  rd_addr_i,
  input  logic [$clog2(TAPS)-1:0]  wr_addr_i,
  input  logic [2*TAP_BITS-1:0]    wr_data_i,
  output logic [2*TAP_BITS-1:0]    rd_data_o
);

  localparam int IW = $clog2(TAPS);
  localparam logic [2*TAP_BITS-1:0] TAP_ONE =
    (2*TAP_BITS)'(1) << (TAP_BITS - 3);

  logic [2*TAP_BITS-1:0] mem [TAPS];
  logic [2*TAP_BITS-1:0] rd_q;
  logic                  ctr_q;
  logic                  init_q;

  // a full update sweep writes every entry, the last one at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
    end else if (req_i.wr_en && (wr_addr_i == IW'(TAPS - 1))) begin
      init_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_q  <= mem[rd_addr_i];
      ctr_q <= (rd_addr_i == IW'(TAPS / 2));
    end
  end

  assign rd_data_o = init_q ? rd_q : (ctr_q ? TAP_ONE : '0);

endmodule

// File: hdl/complex_lms_qpsk_equalizer.sv
// A result is offered once its sample beat has passed the filter sweep and
// the slicer. A new sample is taken only in idle, after the tap update; the
// tap memory is swept once for the filter sum and once for the tap update,
// one tap a cycle. A stalled output holds the block before the tap update.
// Reset: taps read as a centre one and zeros, the delay line as zeros, until
// first written; step size returns to 328. No clearing pass.
module complex_lms_qpsk_equalizer
  import cleq_pkg::*;
#(
  parameter int TAPS     = TAPS_DEF,
  parameter int TAP_BITS = TAP_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*SMP_W-1:0]  s_axis_tdata,   // sample_re, sample_im
  input  logic                s_axis_tlast,   // block_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [2*SMP_W-1:0]  m_axis_tdata,   // eq_re, eq_im
  output logic                m_axis_tlast,   // block_end_out
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [STEP_W-1:0]   cfg_data_i
);

  localparam int IW        = $clog2(TAPS);
  localparam int TB        = TAP_BITS;
  localparam int TF        = TAP_BITS - 3;
  localparam int PR_W      = SMP_W + TB;
  localparam int ACC_W     = SMP_W + TB + 2 + IW;
  localparam int E_W       = SMP_W + 1;
  localparam int ES_W      = E_W + STEP_W + 1;
  localparam int UP_W      = ES_W + SMP_W;
  localparam int PW        = UP_W + 1;
  localparam int SW        = PW + 1;
  localparam int UPD_SHIFT = 41 - TF;

  localparam logic signed [SW-1:0] T_MAX = (SW'(1) <<< (TB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] T_MIN = -T_MAX - SW'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILT  = 3'd1;
  localparam logic [2:0] S_FDRN  = 3'd2;
  localparam logic [2:0] S_SLICE = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_UDRN  = 3'd6;

  function automatic logic signed [SMP_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W-1:0] r;
    r = (a + (ACC_W'(1) <<< (TF - 1))) >>> TF;
    if (r > ACC_W'(SMP_MAX)) begin
      return SMP_W'(SMP_MAX);
    end else if (r < ACC_W'(SMP_MIN)) begin
      return SMP_W'(SMP_MIN);
    end
    return SMP_W'(r);
  endfunction

  function automatic logic signed [TB-1:0] sat_tap(input logic signed [SW-1:0] s);
    if (s > T_MAX) begin
      return TB'(T_MAX);
    end else if (s < T_MIN) begin
      return TB'(T_MIN);
    end
    return TB'(s);
  endfunction

  logic [2:0]               state_q, state_d;
  logic [IW-1:0]            k_q, k1_q, k2_q, k3_q;
  logic                     v1_q, v2_q, v3_q;
  logic                     issue, last_k, s_acc, out_free, filt_ph, upd_ph;
  logic                     blk_q;
  logic [STEP_W-1:0]        step_q;

  dl_req_t                  dl_req;
  tap_req_t                 tap_req;
  logic [2*SMP_W-1:0]       dl_rd;
  logic [2*TB-1:0]          tap_rd, tap_wr;

  logic signed [SMP_W-1:0]  x_re, x_im;
  logic signed [TB-1:0]     w_re, w_im;
  logic signed [PR_W-1:0]   prr_q, pii_q, pri_q, pir_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
  logic signed [SMP_W-1:0]  y_re_q, y_im_q;
  logic                     pos_re_q, pos_im_q;
  logic signed [E_W-1:0]    e_re, e_im;
  logic signed [STEP_W:0]   step_s;
  logic signed [ES_W-1:0]   es_re_q, es_im_q;
  logic signed [UP_W-1:0]   ur1_q, ur2_q, ui1_q, ui2_q;
  logic [2*TB-1:0]          w2_q, w3_q;
  logic signed [PW-1:0]     p_re, p_im, d_re_q, d_im_q;
  logic signed [TB-1:0]     n_re, n_im;

  logic                     out_v_q;
  logic [2*SMP_W-1:0]       out_data_q;
  logic                     out_last_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign issue         = (state_q == S_FILT) || (state_q == S_UPD);
  assign last_k        = (k_q == IW'(TAPS - 1));
  assign out_free      = !out_v_q || m_axis_tready;
  assign filt_ph       = (state_q == S_FILT) || (state_q == S_FDRN);
  assign upd_ph        = (state_q == S_UPD) || (state_q == S_UDRN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (s_acc) state_d = S_FILT;
      S_FILT:  if (last_k) state_d = S_FDRN;
      S_FDRN:  if (!v1_q && !v2_q) state_d = S_SLICE;
      S_SLICE: state_d = S_STEP;
      S_STEP:  if (out_free) state_d = S_UPD;
      S_UPD:   if (last_k) state_d = S_UDRN;
      S_UDRN:  if (!v1_q && !v2_q && !v3_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      step_q  <= STEP_RST;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (issue) begin
        k_q <= last_k ? '0 : k_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
      if ((state_q == S_STEP) && out_free) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign dl_req.wr_en    = s_acc;
  assign dl_req.rd_en    = issue;
  assign dl_req.rd_start = issue && (k_q == '0);

  cleq_dline #(
    .TAPS (TAPS)
  ) u_dline (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dl_req),
    .wr_data_i (s_axis_tdata),
    .rd_data_o (dl_rd)
  );

  assign tap_req.rd_en = issue;
  assign tap_req.wr_en = v3_q && upd_ph;
  assign tap_wr        = {n_im, n_re};

  cleq_tapmem #(
    .TAPS     (TAPS),
    .TAP_BITS (TAP_BITS)
  ) u_tapmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tap_req),
    .rd_addr_i (k_q),
    .wr_addr_i (k3_q),
    .wr_data_i (tap_wr),
    .rd_data_o (tap_rd)
  );

  assign x_re = dl_rd[SMP_W-1:0];
  assign x_im = dl_rd[2*SMP_W-1:SMP_W];
  assign w_re = tap_rd[TB-1:0];
  assign w_im = tap_rd[2*TB-1:TB];

  // error against the nearest constellation point; a zero sum goes negative
  assign e_re = (pos_re_q ? E_W'(QPSK_LEVEL) : -E_W'(QPSK_LEVEL)) - E_W'(y_re_q);
  assign e_im = (pos_im_q ? E_W'(QPSK_LEVEL) : -E_W'(QPSK_LEVEL)) - E_W'(y_im_q);
  assign step_s = $signed({1'b0, step_q});

  // p * mu folded as (e * mu) * conj(x); twice mu via the shorter shift
  assign p_re = PW'(ur1_q) + PW'(ur2_q);
  assign p_im = PW'(ui1_q) - PW'(ui2_q);

  assign n_re = sat_tap(SW'($signed(w3_q[TB-1:0])) + SW'(d_re_q));
  assign n_im = sat_tap(SW'($signed(w3_q[2*TB-1:TB])) + SW'(d_im_q));

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      blk_q    <= s_axis_tlast;
      acc_re_q <= '0;
      acc_im_q <= '0;
    end
    if (issue) begin
      k1_q <= k_q;
    end
    if (v1_q) begin
      prr_q <= x_re * w_re;
      pii_q <= x_im * w_im;
      pri_q <= x_re * w_im;
      pir_q <= x_im * w_re;
      ur1_q <= es_re_q * x_re;
      ur2_q <= es_im_q * x_im;
      ui1_q <= es_im_q * x_re;
      ui2_q <= es_re_q * x_im;
      w2_q  <= tap_rd;
      k2_q  <= k1_q;
    end
    if (v2_q) begin
      if (filt_ph) begin
        acc_re_q <= acc_re_q + ACC_W'(prr_q) - ACC_W'(pii_q);
        acc_im_q <= acc_im_q + ACC_W'(pri_q) + ACC_W'(pir_q);
      end
      d_re_q <= (p_re + (PW'(1) <<< (UPD_SHIFT - 1))) >>> UPD_SHIFT;
      d_im_q <= (p_im + (PW'(1) <<< (UPD_SHIFT - 1))) >>> UPD_SHIFT;
      w3_q   <= w2_q;
      k3_q   <= k2_q;
    end
    if (state_q == S_SLICE) begin
      y_re_q   <= round_sat(acc_re_q);
      y_im_q   <= round_sat(acc_im_q);
      pos_re_q <= (acc_re_q > ACC_W'(0));
      pos_im_q <= (acc_im_q > ACC_W'(0));
    end
    if ((state_q == S_STEP) && out_free) begin
      es_re_q    <= e_re * step_s;
      es_im_q    <= e_im * step_s;
      out_data_q <= {y_im_q, y_re_q};
      out_last_q <= blk_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
